/* design/mulaw_call_path_transcoder_defines.svh */
// ----------------------------------------------------------------------------
// mu-law call path transcoder assertion macros
// Concurrent assertion wrappers used by the transcoder top module. In synthesis
// builds the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef MULAW_CALL_PATH_TRANSCODER_DEFINES_SVH
`define MULAW_CALL_PATH_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS

// Assertion checked outside reset.
`define MLT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mulaw transcoder assertion failed");

// Assertion checked in every cycle, reset included.
`define MLT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("mulaw transcoder reset assertion failed");

`else

`define MLT_ASSERT(lbl, prop)
`define MLT_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* design/mlt_pkg.sv */
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and constants of the mu-law call path transcoder.
// ----------------------------------------------------------------------------
package mlt_pkg;

   // Linear PCM sample.
   typedef logic signed [15:0] pcm_type;

   // Mu-law code byte.
   typedef logic [7:0] ulaw_type;

   // Direction codes carried in the kind field.
   localparam logic KIND_DOWNLINK = 1'b0;
   localparam logic KIND_UPLINK   = 1'b1;

   // Mu-law companding constants.
   localparam logic [7:0]  MU_BIAS  = 8'h84;
   localparam logic [15:0] MU_CLIP  = 16'd32635;
   localparam logic [7:0]  MU_SIGN  = 8'h80;
   localparam logic [3:0]  MU_MAN   = 4'h0F;
   localparam logic [2:0]  MU_EXMAX = 3'h7;

endpackage

/* design/mlt_decode.sv */
// ----------------------------------------------------------------------------
// mlt_decode
// Mu-law byte expansion to linear PCM and midpoint with the previous sample.
// ----------------------------------------------------------------------------
module mlt_decode
   import mlt_pkg::*;
(
   input  ulaw_type code,
   input  pcm_type  prev_sample,
   output pcm_type  decoded,
   output pcm_type  interp
);

   logic [7:0]         inv_code;
   logic [2:0]         exponent;
   logic [3:0]         mantissa;
   logic [7:0]         base;
   logic [14:0]        shifted;
   logic [14:0]        magnitude;
   logic signed [16:0] sum;
   logic signed [16:0] sum_adj;

   // Mu-law codes are transmitted inverted.
   assign inv_code = ~code;
   assign exponent = inv_code[6:4];
   assign mantissa = inv_code[3:0];

   // Rebuild the biased magnitude, then remove the bias.
   assign base      = {1'b0, mantissa, 3'b000} + MU_BIAS;
   assign shifted   = {7'b0, base} << exponent;
   assign magnitude = shifted - {7'b0, MU_BIAS};
   assign decoded   = inv_code[7] ? -pcm_type'({1'b0, magnitude})
                                  :  pcm_type'({1'b0, magnitude});

   // Midpoint, truncated toward zero: negative sums get one added first.
   assign sum     = {prev_sample[15], prev_sample} + {decoded[15], decoded};
   assign sum_adj = sum + {16'b0, sum[16]};
   assign interp  = pcm_type'(sum_adj >>> 1);

endmodule

/* design/mlt_encode.sv */
// ----------------------------------------------------------------------------
// mlt_encode
// Averages a pair of mic samples and compresses the result to mu-law.
// ----------------------------------------------------------------------------
module mlt_encode
   import mlt_pkg::*;
(
   input  pcm_type  mic_first,
   input  pcm_type  mic_second,
   output ulaw_type code
);

   logic signed [16:0] sum;
   logic signed [16:0] sum_adj;
   logic signed [16:0] average;
   logic               sign;
   logic [16:0]        abs_val;
   logic [15:0]        clipped;
   logic [14:0]        biased;
   logic [2:0]         exponent;
   logic [14:0]        man_shift;
   logic [3:0]         mantissa;

   // Average of the pair, truncated toward zero.
   assign sum     = {mic_first[15], mic_first} + {mic_second[15], mic_second};
   assign sum_adj = sum + {16'b0, sum[16]};
   assign average = sum_adj >>> 1;

   // Sign and magnitude; the magnitude is clipped, which also covers -32768.
   assign sign    = average[16];
   assign abs_val = sign ? 17'(-average) : 17'(average);
   assign clipped = (abs_val > {1'b0, MU_CLIP}) ? MU_CLIP : abs_val[15:0];
   assign biased  = clipped[14:0] + {7'b0, MU_BIAS};

   // Segment search: position of the leading one among bits 14 down to 7.
   always_comb begin
      priority if (biased[14]) begin
         exponent = MU_EXMAX;
      end else if (biased[13]) begin
         exponent = 3'd6;
      end else if (biased[12]) begin
         exponent = 3'd5;
      end else if (biased[11]) begin
         exponent = 3'd4;
      end else if (biased[10]) begin
         exponent = 3'd3;
      end else if (biased[9]) begin
         exponent = 3'd2;
      end else if (biased[8]) begin
         exponent = 3'd1;
      end else begin
         exponent = 3'd0;
      end
   end

   // Four mantissa bits below the leading one, then invert the code.
   assign man_shift = biased >> ({1'b0, exponent} + 4'd3);
   assign mantissa  = man_shift[3:0] & MU_MAN;
   assign code      = ~((sign ? MU_SIGN : 8'h00) | {1'b0, exponent, mantissa});

endmodule

/* design/mulaw_call_path_transcoder.sv */
// ----------------------------------------------------------------------------
// mulaw_call_path_transcoder
// Full-duplex G.711 mu-law call path: uplink pairs of 16 kHz samples are
// averaged and encoded, downlink bytes are decoded and interpolated.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req_    | in        | req_valid/req_ready  | kind, ulaw_in, mic pair, flags
//   rsp_    | out       | rsp_valid/rsp_ready  | ulaw_out, interp/decoded, done
//
// Each request passes through the input register and then the result
// register; the block takes one request per cycle unless the result stalls.
// The history updates as a request moves to the result register, so
// consecutive downlink requests chain without a bubble. Synchronous reset
// empties both stages and zeroes the history. A stalled result holds its
// register; the input register takes one more request, then req_ready drops.
// ----------------------------------------------------------------------------
`include "mulaw_call_path_transcoder_defines.svh"

module mulaw_call_path_transcoder
   import mlt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_kind,
   input  ulaw_type req_ulaw_in,
   input  pcm_type  req_mic_first,
   input  pcm_type  req_mic_second,
   input  logic     req_clear_history,
   input  logic     req_chunk_end,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ulaw_type rsp_ulaw_out,
   output pcm_type  rsp_interp_sample,
   output pcm_type  rsp_decoded_sample,
   output logic     rsp_chunk_done
);

   // Input register.
   logic     in_valid_ff, in_valid_in;
   logic     in_kind_ff;
   ulaw_type in_ulaw_ff;
   pcm_type  in_first_ff;
   pcm_type  in_second_ff;
   logic     in_clear_ff;
   logic     in_chunk_ff;

   // Result register and history.
   logic     out_valid_ff, out_valid_in;
   ulaw_type out_ulaw_ff, out_ulaw_in;
   pcm_type  out_interp_ff, out_interp_in;
   pcm_type  out_decoded_ff, out_decoded_in;
   logic     out_chunk_ff;
   pcm_type  prev_ff, prev_in;

   logic     advance;
   logic     req_take;
   pcm_type  prev_used;
   pcm_type  dec_sample;
   pcm_type  dec_interp;
   ulaw_type enc_code;

   // Handshake: the input stage drains when the result register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         prev_ff      <= prev_in;
      end
   end

   // Input payload capture.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff   <= req_kind;
         in_ulaw_ff   <= req_ulaw_in;
         in_first_ff  <= req_mic_first;
         in_second_ff <= req_mic_second;
         in_clear_ff  <= req_clear_history;
         in_chunk_ff  <= req_chunk_end;
      end
   end

   // A clear request treats the history as zero.
   assign prev_used = in_clear_ff ? pcm_type'(0) : prev_ff;

   mlt_decode u_decode (
      .code        (in_ulaw_ff),
      .prev_sample (prev_used),
      .decoded     (dec_sample),
      .interp      (dec_interp)
   );

   mlt_encode u_encode (
      .mic_first  (in_first_ff),
      .mic_second (in_second_ff),
      .code       (enc_code)
   );

   // Result selection; the fields of the other direction read as zero.
   always_comb begin
      prev_in = prev_ff;
      unique case (in_kind_ff)
         KIND_UPLINK: begin
            out_ulaw_in    = enc_code;
            out_interp_in  = '0;
            out_decoded_in = '0;
            if (advance) begin
               prev_in = prev_used;
            end
         end
         default: begin
            out_ulaw_in    = '0;
            out_interp_in  = dec_interp;
            out_decoded_in = dec_sample;
            if (advance) begin
               prev_in = dec_sample;
            end
         end
      endcase
   end

   // Result payload capture.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ulaw_ff    <= out_ulaw_in;
         out_interp_ff  <= out_interp_in;
         out_decoded_ff <= out_decoded_in;
         out_chunk_ff   <= in_chunk_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_ulaw_out       = out_ulaw_ff;
   assign rsp_interp_sample  = out_interp_ff;
   assign rsp_decoded_sample = out_decoded_ff;
   assign rsp_chunk_done     = out_chunk_ff;

   // The result register is empty right after reset.
   `MLT_ASSERT_ALWAYS(a_rsp_empty_after_reset, $past(reset) |-> !rsp_valid)
   // A downlink request leaves its decoded sample in the history.
   `MLT_ASSERT(a_history_follows, (advance && !in_kind_ff) |=> (prev_ff == rsp_decoded_sample))
   // Uplink results carry no downlink samples.
   `MLT_ASSERT(a_uplink_no_decoded, (advance && in_kind_ff) |=> rsp_decoded_sample == '0)
   `MLT_ASSERT(a_uplink_no_interp, (advance && in_kind_ff) |=> rsp_interp_sample == '0)
   // A taken result with nothing behind it leaves the output empty.
   `MLT_ASSERT(a_drain_empty, (rsp_valid && rsp_ready && !in_valid_ff) |=> !rsp_valid)
   // An accepted request always lands in the input register.
   `MLT_ASSERT(a_req_lands, req_take |=> in_valid_ff)

endmodule
